// File: rtl/smou_pkg.sv
// ----------------------------------------------------------------------------
// Small matrix operation unit package
// Function codes, payload types and the pipeline tag shared by all modules.
// ----------------------------------------------------------------------------
package smou_pkg;

   typedef logic [2:0]         func_type;
   typedef logic signed [15:0] elem_type;
   typedef logic signed [32:0] result_type;
   typedef logic [1:0]         coord_type;

   localparam func_type FUNC_WRITE_A = 3'd0;
   localparam func_type FUNC_WRITE_B = 3'd1;
   localparam func_type FUNC_ADD     = 3'd2;
   localparam func_type FUNC_MUL     = 3'd3;
   localparam func_type FUNC_TRANS   = 3'd4;
   localparam func_type FUNC_SEARCH  = 3'd5;
   localparam func_type FUNC_SUM     = 3'd6;

   typedef struct packed {
      logic      valid;
      func_type  op;
      logic      which;
      coord_type row;
      coord_type col;
      logic      first;
      logic      emit;
      logic      tail;
      elem_type  key;
   } tag_type;

endpackage

// File: rtl/smou_if.sv
// ----------------------------------------------------------------------------
// Small matrix operation unit channels
// Valid/ready interfaces for the command and result channels.
// ----------------------------------------------------------------------------
interface smou_req_if;
   logic               valid;
   logic               ready;
   smou_pkg::func_type func;
   smou_pkg::elem_type value;
   logic [1:0]         row;
   logic [1:0]         col;
   logic               which;

   modport source (output valid, func, value, row, col, which, input ready);
   modport sink   (input valid, func, value, row, col, which, output ready);
endinterface

interface smou_rsp_if;
   logic                 valid;
   logic                 ready;
   smou_pkg::result_type result_value;
   logic [1:0]           result_row;
   logic [1:0]           result_col;
   logic                 found;
   logic                 last;

   modport source (output valid, result_value, result_row, result_col, found, last,
                   input ready);
   modport sink   (input valid, result_value, result_row, result_col, found, last,
                   output ready);
endinterface

// File: rtl/smou_ram.sv
// ----------------------------------------------------------------------------
// Small matrix operation unit element memory
// One write port and one registered read port holding one matrix.
// ----------------------------------------------------------------------------
module smou_ram #(
   parameter int DEPTH = 9,
   parameter int AW    = 4
) (
   input  logic               clock,
   input  logic               we,
   input  logic [AW-1:0]      waddr,
   input  smou_pkg::elem_type wdata,
   input  logic               re,
   input  logic [AW-1:0]      raddr,
   output smou_pkg::elem_type rdata
);
   import smou_pkg::*;

   elem_type mem [DEPTH];
   elem_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/smou_seq.sv
// ----------------------------------------------------------------------------
// Small matrix operation unit sequencer
// Accepts commands, performs element writes and walks the read addresses.
// ----------------------------------------------------------------------------
module smou_seq #(
   parameter int DIM = 3,
   parameter int IW  = 2,
   parameter int AW  = 4
) (
   input  logic               clock,
   input  logic               reset,
   smou_req_if.sink           req_ch,
   input  logic               adv,
   input  logic               pipe_done,
   output smou_pkg::tag_type  tag0,
   output logic               we_a,
   output logic               we_b,
   output logic [AW-1:0]      waddr,
   output smou_pkg::elem_type wdata,
   output logic [AW-1:0]      raddr_a,
   output logic [AW-1:0]      raddr_b
);
   import smou_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_ISSUE = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   state_type      state_ff, state_in;
   func_type       op_ff, op_in;
   logic           which_ff, which_in;
   elem_type       key_ff, key_in;
   logic [IW-1:0]  i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [IW-1:0]  kmax;
   logic           accept, wr_ok, is_compute, i_end, j_end, k_end, last0;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign wr_ok        = (int'(req_ch.row) < DIM) && (int'(req_ch.col) < DIM);
   assign is_compute   = req_ch.func inside {[FUNC_ADD:FUNC_SUM]};

   assign we_a  = accept && (req_ch.func == FUNC_WRITE_A) && wr_ok;
   assign we_b  = accept && (req_ch.func == FUNC_WRITE_B) && wr_ok;
   assign waddr = AW'(int'(req_ch.row) * DIM + int'(req_ch.col));
   assign wdata = req_ch.value;

   assign kmax  = (op_ff == FUNC_MUL) ? IW'(DIM - 1) : '0;
   assign i_end = (i_ff == IW'(DIM - 1));
   assign j_end = (j_ff == IW'(DIM - 1));
   assign k_end = (k_ff == kmax);
   assign last0 = i_end && j_end && k_end;

   always_comb begin
      case (op_ff)
         FUNC_MUL: begin
            raddr_a = AW'(int'(i_ff) * DIM + int'(k_ff));
            raddr_b = AW'(int'(k_ff) * DIM + int'(j_ff));
         end
         FUNC_TRANS: begin
            raddr_a = AW'(int'(j_ff) * DIM + int'(i_ff));
            raddr_b = AW'(int'(j_ff) * DIM + int'(i_ff));
         end
         default: begin
            raddr_a = AW'(int'(i_ff) * DIM + int'(j_ff));
            raddr_b = AW'(int'(i_ff) * DIM + int'(j_ff));
         end
      endcase
   end

   always_comb begin
      tag0.valid = (state_ff == ST_ISSUE);
      tag0.op    = op_ff;
      tag0.which = which_ff;
      tag0.row   = 2'(i_ff);
      tag0.col   = 2'(j_ff);
      tag0.key   = key_ff;
      tag0.tail  = last0;
      case (op_ff)
         FUNC_MUL: begin
            tag0.first = (k_ff == '0);
            tag0.emit  = k_end;
         end
         FUNC_SUM, FUNC_SEARCH: begin
            tag0.first = (i_ff == '0) && (j_ff == '0);
            tag0.emit  = last0;
         end
         default: begin
            tag0.first = 1'b1;
            tag0.emit  = 1'b1;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      which_in = which_ff;
      key_in   = key_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && is_compute) begin
               state_in = ST_ISSUE;
               op_in    = req_ch.func;
               which_in = req_ch.which;
               key_in   = req_ch.value;
               i_in     = '0;
               j_in     = '0;
               k_in     = '0;
            end
         end
         ST_ISSUE: begin
            if (adv) begin
               if (!k_end) begin
                  k_in = k_ff + IW'(1);
               end else begin
                  k_in = '0;
                  if (!j_end) begin
                     j_in = j_ff + IW'(1);
                  end else begin
                     j_in = '0;
                     if (!i_end) begin
                        i_in = i_ff + IW'(1);
                     end else begin
                        i_in     = '0;
                        state_in = ST_DRAIN;
                     end
                  end
               end
            end
         end
         ST_DRAIN: begin
            if (pipe_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      op_ff    <= op_in;
      which_ff <= which_in;
      key_ff   <= key_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      k_ff     <= k_in;
   end

endmodule

// File: rtl/smou_alu.sv
// ----------------------------------------------------------------------------
// Small matrix operation unit arithmetic pipeline
// Forms terms from the memory read data, accumulates them and holds results.
// ----------------------------------------------------------------------------
module smou_alu (
   input  logic               clock,
   input  logic               reset,
   input  smou_pkg::tag_type  tag0,
   input  smou_pkg::elem_type rdata_a,
   input  smou_pkg::elem_type rdata_b,
   output logic               adv,
   output logic               pipe_done,
   smou_rsp_if.source         rsp_ch
);
   import smou_pkg::*;

   tag_type            tag1_ff, tag2_ff;
   result_type         term_ff, term_in;
   logic               hit_ff, hit_in;
   result_type         acc_ff, acc_in;
   logic               seen_ff, prior, emit_hit, emit_miss, out_load;
   logic signed [31:0] prod;
   elem_type           sel;
   logic               out_valid_ff;
   result_type         out_value_ff, out_value_in;
   coord_type          out_row_ff, out_row_in, out_col_ff, out_col_in;
   logic               out_found_ff, out_found_in, out_last_ff, out_last_in;

   assign adv  = !out_valid_ff || rsp_ch.ready;
   assign prod = rdata_a * rdata_b;
   assign sel  = tag1_ff.which ? rdata_b : rdata_a;

   always_comb begin
      hit_in = (rdata_a == tag1_ff.key);
      case (tag1_ff.op)
         FUNC_ADD: term_in = 33'(rdata_a) + 33'(rdata_b);
         FUNC_MUL: term_in = 33'(prod);
         default:  term_in = 33'(sel);
      endcase
   end

   assign acc_in    = tag2_ff.first ? term_ff : acc_ff + term_ff;
   assign prior     = tag2_ff.first ? 1'b0 : seen_ff;
   assign emit_hit  = hit_ff && !prior;
   assign emit_miss = tag2_ff.tail && !hit_ff && !prior;
   assign pipe_done = adv && tag2_ff.valid && tag2_ff.tail;

   always_comb begin
      out_value_in = acc_in;
      out_row_in   = tag2_ff.row;
      out_col_in   = tag2_ff.col;
      out_found_in = 1'b0;
      out_last_in  = tag2_ff.tail;
      out_load     = adv && tag2_ff.valid && tag2_ff.emit;
      case (tag2_ff.op)
         FUNC_SEARCH: begin
            out_load     = adv && tag2_ff.valid && (emit_hit || emit_miss);
            out_value_in = emit_hit ? 33'(tag2_ff.key) : '0;
            out_row_in   = emit_hit ? tag2_ff.row : '0;
            out_col_in   = emit_hit ? tag2_ff.col : '0;
            out_found_in = emit_hit;
            out_last_in  = 1'b1;
         end
         FUNC_SUM: begin
            out_row_in = '0;
            out_col_in = '0;
         end
         default: begin
            out_found_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff      <= '0;
         tag2_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (adv) begin
            tag1_ff <= tag0;
            tag2_ff <= tag1_ff;
         end
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (adv) begin
         term_ff <= term_in;
         hit_ff  <= hit_in;
      end
      if (adv && tag2_ff.valid) begin
         acc_ff  <= acc_in;
         seen_ff <= prior || hit_ff;
      end
      if (out_load) begin
         out_value_ff <= out_value_in;
         out_row_ff   <= out_row_in;
         out_col_ff   <= out_col_in;
         out_found_ff <= out_found_in;
         out_last_ff  <= out_last_in;
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.result_value = out_value_ff;
   assign rsp_ch.result_row   = out_row_ff;
   assign rsp_ch.result_col   = out_col_ff;
   assign rsp_ch.found        = out_found_ff;
   assign rsp_ch.last         = out_last_ff;

endmodule

// File: rtl/small_matrix_operation_unit_core.sv
// ----------------------------------------------------------------------------
// Small matrix operation unit core
// Holds two DIM by DIM signed matrices and adds, multiplies, transposes,
// searches and sums them on command.
// ----------------------------------------------------------------------------
// A write transaction stores one element and returns nothing. Add, transpose,
// search and sum walk the DIM*DIM elements at one memory read per cycle while
// the result channel does not stall. Multiply forms each dot product one term
// per cycle, under the same condition, through the single multiplier fed by
// the two memory read ports, walking DIM*DIM*DIM terms in all for DIM*DIM
// results. A new command is taken once the last element of the current one
// has left the pipeline, even while its final result still waits on the
// result channel. The memories need no initialization after reset.
// ----------------------------------------------------------------------------
module small_matrix_operation_unit_core #(
   parameter int DIM = 3
) (
   input  logic       clock,
   input  logic       reset,
   smou_req_if.sink   req_ch,
   smou_rsp_if.source rsp_ch
);
   import smou_pkg::*;

   localparam int DEPTH = DIM * DIM;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int IW    = (DIM > 1) ? $clog2(DIM) : 1;

   tag_type         tag0;
   logic            adv, pipe_done, we_a, we_b;
   logic [AW-1:0]   waddr, raddr_a, raddr_b;
   elem_type        wdata, rdata_a, rdata_b;

   smou_seq #(.DIM(DIM), .IW(IW), .AW(AW)) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .adv       (adv),
      .pipe_done (pipe_done),
      .tag0      (tag0),
      .we_a      (we_a),
      .we_b      (we_b),
      .waddr     (waddr),
      .wdata     (wdata),
      .raddr_a   (raddr_a),
      .raddr_b   (raddr_b)
   );

   smou_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram_a (
      .clock (clock),
      .we    (we_a),
      .waddr (waddr),
      .wdata (wdata),
      .re    (adv),
      .raddr (raddr_a),
      .rdata (rdata_a)
   );

   smou_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram_b (
      .clock (clock),
      .we    (we_b),
      .waddr (waddr),
      .wdata (wdata),
      .re    (adv),
      .raddr (raddr_b),
      .rdata (rdata_b)
   );

   smou_alu u_alu (
      .clock     (clock),
      .reset     (reset),
      .tag0      (tag0),
      .rdata_a   (rdata_a),
      .rdata_b   (rdata_b),
      .adv       (adv),
      .pipe_done (pipe_done),
      .rsp_ch    (rsp_ch)
   );

endmodule
